/* hw/rtl/wbps_pkg.sv */
`default_nettype none
package wbps_pkg;

   localparam int BYTE_W       = 8;
   localparam int CFG_WORD_W   = 64;
   localparam int MASK_W       = 16;
   localparam int LEN_REG_W    = 5;
   localparam int CSR_INDEX_W  = 8;
   localparam int OFFSET_OUT_W = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 8'd0,
      CSR_PATTERN_HIGH   = 8'd1,
      CSR_WILDCARD_MASK  = 8'd2,
      CSR_PATTERN_LENGTH = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] pattern;
      logic              wild;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* hw/rtl/wbps_cell.sv */
`default_nettype none
module wbps_cell
   import wbps_pkg::*;
#(
   parameter bit KEEP = 1'b1
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [BYTE_W-1:0] byte_in,
   input  wire cell_ctl_type      ctl,
   output logic                   hit,
   output logic [BYTE_W-1:0]      byte_out
);

   assign hit = ctl.wild || (byte_in == ctl.pattern);

   generate
      if (KEEP) begin : g_keep
         logic [BYTE_W-1:0] held_ff;
         logic [BYTE_W-1:0] held_in;

         assign held_in = advance ? byte_in : held_ff;

         always_ff @(posedge clock) begin
            held_ff <= held_in;
         end

         assign byte_out = held_ff;
      end else begin : g_end
         assign byte_out = '0;
      end
   endgenerate

endmodule
`default_nettype wire

/* hw/rtl/wbps_cfg.sv */
`default_nettype none
module wbps_cfg
   import wbps_pkg::*;
#(
   parameter  int PATTERN_MAX = 16,
   localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [CFG_WORD_W-1:0]             csr_wdata,
   output cell_ctl_type [PATTERN_MAX-1:0]         cell_ctl,
   output logic [IDX_W-1:0]                       len_m1
);

   logic [CFG_WORD_W-1:0] pattern_low_ff, pattern_low_in;
   logic [CFG_WORD_W-1:0] pattern_high_ff, pattern_high_in;
   logic [MASK_W-1:0]     mask_ff, mask_in;
   logic [LEN_REG_W-1:0]  length_ff, length_in;

   logic [2*CFG_WORD_W-1:0]        pattern_all;
   logic [BYTE_W-1:0]              pat_bytes [PATTERN_MAX];
   logic [IDX_W-1:0]               len_m1_ff, len_m1_in;
   cell_ctl_type [PATTERN_MAX-1:0] ctl_ff, ctl_in;

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      mask_in         = mask_ff;
      length_in       = length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_in  = csr_wdata;
            CSR_PATTERN_HIGH:   pattern_high_in = csr_wdata;
            CSR_WILDCARD_MASK:  mask_in         = csr_wdata[MASK_W-1:0];
            CSR_PATTERN_LENGTH: length_in       = csr_wdata[LEN_REG_W-1:0];
            default: ;
         endcase
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   generate
      for (genvar m = 0; m < PATTERN_MAX; m++) begin : g_bytes
         assign pat_bytes[m] = pattern_all[m*BYTE_W +: BYTE_W];
      end
   endgenerate

   // clamp the length to one..PATTERN_MAX
   always_comb begin
      if (length_ff == '0) begin
         len_m1_in = '0;
      end else if (length_ff > LEN_REG_W'(PATTERN_MAX)) begin
         len_m1_in = IDX_W'(PATTERN_MAX - 1);
      end else begin
         len_m1_in = IDX_W'(length_ff - LEN_REG_W'(1));
      end
   end

   // cell j sees the byte j places back, which meets pattern byte len-1-j
   always_comb begin
      logic [IDX_W-1:0] k;
      k = '0;
      for (int j = 0; j < PATTERN_MAX; j++) begin
         k = len_m1_in - IDX_W'(j);
         if (IDX_W'(j) <= len_m1_in) begin
            ctl_in[j].pattern = pat_bytes[k];
            ctl_in[j].wild    = mask_ff[k];
         end else begin
            ctl_in[j].pattern = '0;
            ctl_in[j].wild    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         mask_ff         <= '0;
         length_ff       <= LEN_REG_W'(1);
         len_m1_ff       <= '0;
         for (int j = 0; j < PATTERN_MAX; j++) begin
            ctl_ff[j].pattern <= '0;
            ctl_ff[j].wild    <= (j != 0);
         end
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         mask_ff         <= mask_in;
         length_ff       <= length_in;
         len_m1_ff       <= len_m1_in;
         ctl_ff          <= ctl_in;
      end
   end

   assign cell_ctl = ctl_ff;
   assign len_m1   = len_m1_ff;

endmodule
`default_nettype wire

/* hw/rtl/wildcard_byte_pattern_scan.sv */
// Wildcard byte pattern scan.
// Bytes of a memory image enter on the req_ stream, one word per byte, with
// req_tlast on the final byte of the image. Each image yields exactly one
// word on the rsp_ stream: rsp_tuser high with the offset of the first match
// in rsp_tdata, or rsp_tuser low and zero offset when the image ends without
// a match. Bytes after a match produce nothing until the image ends.
// The pattern (up to PATTERN_MAX bytes), wildcard mask and length sit in
// registers written over the csr_ port between images; req_tready drops in
// the cycle after each write, so the next byte sees the new values.
// Throughput is one byte per cycle unless stalled: a row of cells holds the
// byte window and compares every position in parallel, and the result is
// registered, so a response appears in the cycle after the byte that
// completes it. req_tready stays high while the response register is empty
// or being taken and no write is pending; a stalled receiver holds the
// response and stalls the input. Reset clears the position count, match
// flag, response register and all config registers (length back to one).
`default_nettype none
module wildcard_byte_pattern_scan
   import wbps_pkg::*;
#(
   parameter int PATTERN_MAX = 16,
   parameter int OFFSET_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [BYTE_W-1:0]       req_tdata,   // data_byte
   input  wire logic                    req_tlast,   // last_byte
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [OFFSET_OUT_W-1:0]      rsp_tdata,   // match_offset
   output logic                         rsp_tuser,   // found
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CFG_WORD_W-1:0]   csr_wdata
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   cell_ctl_type [PATTERN_MAX-1:0] cell_ctl;
   logic [IDX_W-1:0]               len_m1;
   logic [BYTE_W-1:0]              chain [PATTERN_MAX];
   logic [PATTERN_MAX-1:0]         hits;

   logic                      in_accept;
   logic [OFFSET_BITS-1:0]    pos_ff, pos_in;
   logic                      matched_ff, matched_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [OFFSET_OUT_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic                      cfg_wait_ff, cfg_wait_in;
   logic [OFFSET_BITS-1:0]    start_pos;
   logic                      reach;
   logic                      match;

   assign csr_ready = 1'b1;

   wbps_cfg #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cell_ctl  (cell_ctl),
      .len_m1    (len_m1)
   );

   assign chain[0] = req_tdata;

   generate
      for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
         if (j < PATTERN_MAX - 1) begin : g_mid
            wbps_cell #(
               .KEEP (1'b1)
            ) u_cell (
               .clock    (clock),
               .advance  (in_accept),
               .byte_in  (chain[j]),
               .ctl      (cell_ctl[j]),
               .hit      (hits[j]),
               .byte_out (chain[j+1])
            );
         end else begin : g_tail
            wbps_cell #(
               .KEEP (1'b0)
            ) u_cell (
               .clock    (clock),
               .advance  (in_accept),
               .byte_in  (chain[j]),
               .ctl      (cell_ctl[j]),
               .hit      (hits[j]),
               .byte_out ()
            );
         end
      end
   endgenerate

   // hold the input while a fresh register write settles into the cells
   assign cfg_wait_in = csr_valid && csr_ready;

   assign req_tready = (!rsp_valid_ff || rsp_tready) && !cfg_wait_ff;
   assign in_accept  = req_tvalid && req_tready;

   assign reach     = pos_ff >= OFFSET_BITS'(len_m1);
   assign match     = reach && (&hits);
   assign start_pos = pos_ff - OFFSET_BITS'(len_m1);

   always_comb begin
      pos_in        = pos_ff;
      matched_in    = matched_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;
      if (in_accept) begin
         if (!matched_ff) begin
            if (match) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_offset_in = OFFSET_OUT_W'(start_pos);
               matched_in    = 1'b1;
            end else if (req_tlast) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_offset_in = '0;
            end
            if (pos_ff != '1) begin
               pos_in = pos_ff + OFFSET_BITS'(1);
            end
         end
         if (req_tlast) begin
            pos_in     = '0;
            matched_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         matched_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_wait_ff  <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         matched_ff   <= matched_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_wait_ff  <= cfg_wait_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = rsp_offset_ff;

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("not-found response with nonzero offset");

   a_image_clear: assert property (@(posedge clock) disable iff (reset)
      in_accept && req_tlast |=> pos_ff == '0 && !matched_ff)
      else $error("image state not cleared after last byte");

   a_no_second_result: assert property (@(posedge clock) disable iff (reset)
      in_accept && matched_ff |=> rsp_valid_ff == ($past(rsp_valid_ff) && !$past(rsp_tready)))
      else $error("response produced after match already reported");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_valid_ff && !rsp_tready) || cfg_wait_ff)
      else $error("input stalled without a held response or register write");

endmodule
`default_nettype wire
